@@ rtl/rwmc_pkg.sv @@
// rwmc_pkg: shared types and codes for the random walk maze carver
`default_nettype none

package rwmc_pkg;

  // widths fixed by the item fields and the registers
  localparam int COORD_W = 6;
  localparam int CFG_W   = 7;

  // reset value of both size registers
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd31;

  // smallest usable grid size
  localparam int SIZE_MIN = 3;

  // register indexes on the configuration port
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // item modes
  localparam logic [1:0] MODE_DRAW    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // walk directions
  localparam logic [1:0] DIR_POS_X = 2'd0;
  localparam logic [1:0] DIR_POS_Y = 2'd1;
  localparam logic [1:0] DIR_NEG_X = 2'd2;
  localparam logic [1:0] DIR_NEG_Y = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_SEAT,
    S_IDLE,
    S_TRY_MID,
    S_TRY_FAR,
    S_CHECK,
    S_CARVE_MID,
    S_CARVE_FAR,
    S_ADVANCE,
    S_OPEN_ENTRY,
    S_OPEN_EXIT,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } state_t;

  // one result item
  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] mid_x;
    logic [COORD_W-1:0] mid_y;
    logic [COORD_W-1:0] far_x;
    logic [COORD_W-1:0] far_y;
    logic               start_advanced;
    logic               finished;
    logic               cell_is_wall;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/random_walk_maze_carver.sv @@
// random_walk_maze_carver: random walk maze carver over a single-port wall-bit memory
//
//   channel   dir  handshake                 payload
//   in        in   in_valid / in_stall       mode, direction, read_x, read_y
//   out       out  out_valid / out_stall     carved, mid_x, mid_y, far_x, far_y,
//                                            start_advanced, finished, cell_is_wall
//   cfg       in   cfg_we (no wait)          cfg_index, cfg_data
//
// One item at a time through one single-port memory with registered read data.
// A draw tries directions in turn: an in-bounds try reads the mid cell, reads the far cell
// and checks both, an out-of-bounds try is skipped, up to 4 tries. Then come 2 carve writes
// or a start advance, plus entry/exit opening once the last start cell is used; then the
// result is posted and the sequencer returns to idle. A finished draw posts at once, as does
// an out-of-range read; an in-range read reads the memory first. After reset and after
// each restart item a clearing pass writes every memory word, input stalled.
// The result register lets the next item enter while a result waits on out_stall;
// a second finished result then waits in the post state until the register frees.
`default_nettype none

module random_walk_maze_carver #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      mode,
  input  wire logic [1:0]                      direction,
  input  wire logic [rwmc_pkg::COORD_W-1:0]    read_x,
  input  wire logic [rwmc_pkg::COORD_W-1:0]    read_y,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 carved,
  output logic [rwmc_pkg::COORD_W-1:0]         mid_x,
  output logic [rwmc_pkg::COORD_W-1:0]         mid_y,
  output logic [rwmc_pkg::COORD_W-1:0]         far_x,
  output logic [rwmc_pkg::COORD_W-1:0]         far_y,
  output logic                                 start_advanced,
  output logic                                 finished,
  output logic                                 cell_is_wall,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [rwmc_pkg::CFG_W-1:0]      cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  localparam int SZW   = ((XW > YW) ? XW : YW) + 2;
  localparam int SCW   = SZW + 1;

  typedef logic signed [SCW-1:0] scoord_t;

  // registers
  rwmc_pkg::state_t           state, state_next;
  logic [rwmc_pkg::CFG_W-1:0] grid_width, grid_height;
  logic [XW-1:0]              walk_col, start_col, rd_x;
  logic [YW-1:0]              walk_row, start_row, rd_y;
  logic                       done_flag;
  logic [1:0]                 dir;
  logic [1:0]                 try_cnt;
  logic                       mid_wall;
  logic                       pend_out;
  logic [AW-1:0]              clr_cnt;
  rwmc_pkg::result_t          res, out_res;

  // memory port
  logic                       mem [DEPTH];
  logic                       mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0]              mem_addr;

  // sizes in use
  int                         w_int, h_int;
  logic [SZW-1:0]             w_use, h_use;

  always_comb begin
    if (int'(grid_width) < rwmc_pkg::SIZE_MIN) begin
      w_int = rwmc_pkg::SIZE_MIN;
    end else if (int'(grid_width) > MAX_WIDTH) begin
      w_int = MAX_WIDTH;
    end else begin
      w_int = int'(grid_width);
    end
    if (int'(grid_height) < rwmc_pkg::SIZE_MIN) begin
      h_int = rwmc_pkg::SIZE_MIN;
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      h_int = MAX_HEIGHT;
    end else begin
      h_int = int'(grid_height);
    end
    w_use = SZW'(w_int);
    h_use = SZW'(h_int);
  end

  // step offsets of the current try
  scoord_t dx, dy, x1, y1, x2, y2, w_s, h_s;
  logic    in_bounds;
  logic [AW-1:0] mid_addr, far_addr, seat_addr, entry_addr, exit_addr, rd_addr;

  always_comb begin
    dx = '0;
    dy = '0;
    unique case (dir)
      rwmc_pkg::DIR_POS_X: dx = scoord_t'(1);
      rwmc_pkg::DIR_POS_Y: dy = scoord_t'(1);
      rwmc_pkg::DIR_NEG_X: dx = -scoord_t'(1);
      rwmc_pkg::DIR_NEG_Y: dy = -scoord_t'(1);
    endcase
    x1  = scoord_t'(walk_col) + dx;
    y1  = scoord_t'(walk_row) + dy;
    x2  = x1 + dx;
    y2  = y1 + dy;
    w_s = scoord_t'(w_use);
    h_s = scoord_t'(h_use);
    in_bounds = (x2 > 0) && (x2 < w_s) && (y2 > 0) && (y2 < h_s) && (x1 >= 0) && (y1 >= 0);
  end

  // cell addresses, row stride of 2**XW
  assign mid_addr   = {y1[YW-1:0], x1[XW-1:0]};
  assign far_addr   = {y2[YW-1:0], x2[XW-1:0]};
  assign seat_addr  = {YW'(1), XW'(1)};
  assign entry_addr = {YW'(0), XW'(1)};
  assign exit_addr  = {YW'(h_use - SZW'(1)), XW'(w_use - SZW'(2))};
  assign rd_addr    = {rd_y, rd_x};

  // next start cell after a stuck walk
  logic          start_last;
  logic [XW-1:0] start_col_next;
  logic [YW-1:0] start_row_next;

  always_comb begin
    start_last     = 1'b0;
    start_col_next = start_col;
    start_row_next = start_row;
    if (SZW'(start_col) + SZW'(2) < w_use) begin
      start_col_next = start_col + XW'(2);
    end else if (SZW'(start_row) + SZW'(2) < h_use) begin
      start_row_next = start_row + YW'(2);
      start_col_next = XW'(1);
    end else begin
      start_last = 1'b1;
    end
  end

  logic read_in_range, last_try, both_wall, out_free;

  assign read_in_range = (int'(read_x) < int'(w_use)) && (int'(read_y) < int'(h_use));
  assign last_try      = (try_cnt == 2'd3);
  assign both_wall     = mid_wall && mem_rdata;
  assign out_free      = !out_valid || !out_stall;

  // result cleared at item entry, and the result posted with the current done flag
  rwmc_pkg::result_t res_first, res_done;

  always_comb begin
    res_first              = '0;
    res_first.cell_is_wall = (mode == rwmc_pkg::MODE_READ) && !read_in_range;
    res_done               = res;
    res_done.finished      = done_flag;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rwmc_pkg::S_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = rwmc_pkg::S_SEAT;
      end
      rwmc_pkg::S_SEAT: begin
        state_next = pend_out ? rwmc_pkg::S_DONE : rwmc_pkg::S_IDLE;
      end
      rwmc_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (mode)
            rwmc_pkg::MODE_DRAW:
              state_next = done_flag ? rwmc_pkg::S_DONE : rwmc_pkg::S_TRY_MID;
            rwmc_pkg::MODE_READ:
              state_next = read_in_range ? rwmc_pkg::S_READ : rwmc_pkg::S_DONE;
            rwmc_pkg::MODE_RESTART:
              state_next = rwmc_pkg::S_CLEAR;
            default:
              state_next = rwmc_pkg::S_DONE;
          endcase
        end
      end
      rwmc_pkg::S_TRY_MID: begin
        if (in_bounds) begin
          state_next = rwmc_pkg::S_TRY_FAR;
        end else if (last_try) begin
          state_next = rwmc_pkg::S_ADVANCE;
        end
      end
      rwmc_pkg::S_TRY_FAR:   state_next = rwmc_pkg::S_CHECK;
      rwmc_pkg::S_CHECK: begin
        if (both_wall) begin
          state_next = rwmc_pkg::S_CARVE_MID;
        end else if (last_try) begin
          state_next = rwmc_pkg::S_ADVANCE;
        end else begin
          state_next = rwmc_pkg::S_TRY_MID;
        end
      end
      rwmc_pkg::S_CARVE_MID: state_next = rwmc_pkg::S_CARVE_FAR;
      rwmc_pkg::S_CARVE_FAR: state_next = rwmc_pkg::S_DONE;
      rwmc_pkg::S_ADVANCE: begin
        state_next = start_last ? rwmc_pkg::S_OPEN_ENTRY : rwmc_pkg::S_DONE;
      end
      rwmc_pkg::S_OPEN_ENTRY: state_next = rwmc_pkg::S_OPEN_EXIT;
      rwmc_pkg::S_OPEN_EXIT:  state_next = rwmc_pkg::S_DONE;
      rwmc_pkg::S_READ:       state_next = rwmc_pkg::S_READ_WAIT;
      rwmc_pkg::S_READ_WAIT:  state_next = rwmc_pkg::S_DONE;
      rwmc_pkg::S_DONE: begin
        if (out_free) state_next = rwmc_pkg::S_IDLE;
      end
      default: state_next = rwmc_pkg::S_CLEAR;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_addr  = rd_addr;
    in_stall  = (state != rwmc_pkg::S_IDLE);
    unique case (state)
      rwmc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        mem_addr  = clr_cnt;
      end
      rwmc_pkg::S_SEAT: begin
        mem_we   = 1'b1;
        mem_addr = seat_addr;
      end
      rwmc_pkg::S_TRY_MID:    mem_addr = mid_addr;
      rwmc_pkg::S_TRY_FAR:    mem_addr = far_addr;
      rwmc_pkg::S_CARVE_MID: begin
        mem_we   = 1'b1;
        mem_addr = mid_addr;
      end
      rwmc_pkg::S_CARVE_FAR: begin
        mem_we   = 1'b1;
        mem_addr = far_addr;
      end
      rwmc_pkg::S_OPEN_ENTRY: begin
        mem_we   = 1'b1;
        mem_addr = entry_addr;
      end
      rwmc_pkg::S_OPEN_EXIT: begin
        mem_we   = 1'b1;
        mem_addr = exit_addr;
      end
      rwmc_pkg::S_READ:       mem_addr = rd_addr;
      default:                mem_addr = rd_addr;
    endcase
  end

  // wall-bit memory, read first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // sequencer and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rwmc_pkg::S_CLEAR;
      grid_width  <= rwmc_pkg::SIZE_RESET;
      grid_height <= rwmc_pkg::SIZE_RESET;
      clr_cnt     <= '0;
      pend_out    <= 1'b0;
      out_valid   <= 1'b0;
      done_flag   <= 1'b0;
      try_cnt     <= '0;
      walk_col    <= XW'(1);
      walk_row    <= YW'(1);
      start_col   <= XW'(1);
      start_row   <= YW'(1);
    end else begin
      state <= state_next;

      // size registers
      if (cfg_we) begin
        unique case (cfg_index)
          rwmc_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data;
          rwmc_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data;
        endcase
      end

      // result register
      if (state == rwmc_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_res   <= res_done;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        rwmc_pkg::S_IDLE: begin
          if (in_valid) begin
            dir     <= direction;
            try_cnt <= '0;
            rd_x    <= XW'(read_x);
            rd_y    <= YW'(read_y);
            res     <= res_first;
            if (mode == rwmc_pkg::MODE_RESTART) begin
              pend_out <= 1'b1;
            end
          end
        end
        rwmc_pkg::S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        rwmc_pkg::S_SEAT: begin
          pend_out  <= 1'b0;
          done_flag <= 1'b0;
          walk_col  <= XW'(1);
          walk_row  <= YW'(1);
          start_col <= XW'(1);
          start_row <= YW'(1);
        end
        rwmc_pkg::S_TRY_MID: begin
          if (!in_bounds) begin
            dir     <= dir + 2'd1;
            try_cnt <= try_cnt + 2'd1;
          end
        end
        rwmc_pkg::S_TRY_FAR: begin
          mid_wall <= mem_rdata;
        end
        rwmc_pkg::S_CHECK: begin
          if (both_wall) begin
            res.carved <= 1'b1;
            res.mid_x  <= rwmc_pkg::COORD_W'(x1[XW-1:0]);
            res.mid_y  <= rwmc_pkg::COORD_W'(y1[YW-1:0]);
            res.far_x  <= rwmc_pkg::COORD_W'(x2[XW-1:0]);
            res.far_y  <= rwmc_pkg::COORD_W'(y2[YW-1:0]);
          end else begin
            dir     <= dir + 2'd1;
            try_cnt <= try_cnt + 2'd1;
          end
        end
        rwmc_pkg::S_CARVE_FAR: begin
          walk_col <= x2[XW-1:0];
          walk_row <= y2[YW-1:0];
        end
        rwmc_pkg::S_ADVANCE: begin
          res.start_advanced <= 1'b1;
          start_col <= start_col_next;
          start_row <= start_row_next;
          walk_col  <= start_col_next;
          walk_row  <= start_row_next;
          if (start_last) begin
            done_flag <= 1'b1;
          end
        end
        rwmc_pkg::S_READ_WAIT: begin
          res.cell_is_wall <= mem_rdata;
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  assign carved         = out_res.carved;
  assign mid_x          = out_res.mid_x;
  assign mid_y          = out_res.mid_y;
  assign far_x          = out_res.far_x;
  assign far_y          = out_res.far_y;
  assign start_advanced = out_res.start_advanced;
  assign finished       = out_res.finished;
  assign cell_is_wall   = out_res.cell_is_wall;

endmodule

`default_nettype wire
